FILE: sv/thsm_pkg.sv
// Shared types and constants for the two-wire humidity sensor master.
// Used by thsm_cfg, thsm_seq and two_wire_humidity_sensor_master; no dependencies.
package thsm_pkg;

	localparam int HalfW    = 16;
	localparam int CmdW     = 8;
	localparam int IdxW     = 5;
	localparam int ReadW    = 16;
	localparam int DataW    = 32;
	localparam int AddrW    = 2;

	localparam logic [HalfW-1:0] HalfReset = 16'd80;
	localparam logic [AddrW-1:0] AddrHalf  = 2'd0;

	localparam logic [CmdW-1:0] CmdTemp  = 8'd3;
	localparam logic [CmdW-1:0] CmdHumid = 8'd5;

	localparam logic [IdxW-1:0] StartLast = 5'd6;
	localparam logic [IdxW-1:0] WriteLast = 5'd24;
	localparam logic [IdxW-1:0] ReadLast  = 5'd15;
	localparam logic [IdxW-1:0] AckLast   = 5'd2;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START     = 4'd1,
		PH_WRITE     = 4'd2,
		PH_ACK_WAIT  = 4'd3,
		PH_ACK_CLOCK = 4'd4,
		PH_MEAS_WAIT = 4'd5,
		PH_READ_HI   = 4'd6,
		PH_ACK_SEND  = 4'd7,
		PH_READ_LO   = 4'd8,
		PH_NACK      = 4'd9
	} phase_t;

	typedef struct packed {
		logic            kind;
		logic [CmdW-1:0] command;
		logic            data_sample;
	} item_t;

	typedef struct packed {
		logic             clock_level;
		logic             data_drive;
		logic             data_level;
		logic             busy_res;
		logic             reading_valid;
		logic [ReadW-1:0] reading;
	} result_t;

endpackage

FILE: sv/two_wire_humidity_sensor_master.sv
// Top level of the two-wire humidity sensor master: input stage, sequencer, result stage.
// Depends on thsm_pkg, thsm_cfg and thsm_seq.
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+------------------------------------------
//   input    | in_valid / in_ready           | kind, command, data_sample
//   result   | out_valid / out_ready         | clock_level, data_drive, data_level,
//            |                               | busy_res, reading_valid, reading
//   config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One transfer is taken per clock unless the result side stalls; a tick passes from the
// input register through the sequencer step into the result register.
// The sequencer state loop (phase, index, delay counter) sets the one-per-cycle rate.
// Reset clears the link to idle with the clock high and data driven high.
// A stalled result holds the result register; an empty input register still takes one
// transfer before in_ready drops.
module two_wire_humidity_sensor_master
	import thsm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             kind,
	input  logic [CmdW-1:0]  command,
	input  logic             data_sample,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             clock_level,
	output logic             data_drive,
	output logic             data_level,
	output logic             busy_res,
	output logic             reading_valid,
	output logic [ReadW-1:0] reading
);

	logic [HalfW-1:0] half_period;
	logic             valid_s1;
	item_t            item_s1;
	logic             out_valid_q;
	result_t          result_q;
	result_t          step_res;
	logic             out_free;
	logic             step;

	thsm_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.half_period (half_period)
	);

	assign out_free = !out_valid_q || out_ready;
	assign step     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{kind: kind, command: command, data_sample: data_sample};
		end
	end

	thsm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (item_s1),
		.half_period (half_period),
		.result      (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= step_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign clock_level   = result_q.clock_level;
	assign data_drive    = result_q.data_drive;
	assign data_level    = result_q.data_level;
	assign busy_res      = result_q.busy_res;
	assign reading_valid = result_q.reading_valid;
	assign reading       = result_q.reading;

endmodule

FILE: sv/thsm_cfg.sv
// APB-style configuration register: half period of the serial clock.
// Depends on thsm_pkg.
module thsm_cfg
	import thsm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready,
	output logic [HalfW-1:0] half_period
);

	logic [HalfW-1:0] half_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HalfReset;
		end else if (psel && penable && pwrite && paddr == AddrHalf) begin
			half_q <= pwdata[HalfW-1:0];
		end
	end

	assign pready      = 1'b1;
	assign prdata      = (paddr == AddrHalf) ? {{(DataW-HalfW){1'b0}}, half_q} : '0;
	assign half_period = half_q;

endmodule

FILE: sv/thsm_seq.sv
// Line sequencer: holds the link state and computes one tick step per enable.
// Depends on thsm_pkg.
module thsm_seq
	import thsm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  item_t            item,
	input  logic [HalfW-1:0] half_period,
	output result_t          result
);

	phase_t            phase_q, phase_d;
	logic [IdxW-1:0]   idx_q, idx_d;
	logic [ReadW-1:0]  shift_q, shift_d;
	logic [CmdW-1:0]   cmd_q, cmd_d;
	logic [HalfW-1:0]  delay_q, delay_d;
	logic              clk_q, clk_d;
	logic              drv_q, drv_d;
	logic              lvl_q, lvl_d;
	logic              done;

	// Scratch for the advance step
	phase_t            ph;
	logic [IdxW-1:0]   k;
	logic              do_adv;
	logic              waiting;
	logic [HalfW-1:0]  hp;
	logic [IdxW+3:0]   k11;
	logic [2:0]        quot;
	logic [1:0]        sub;
	logic [2:0]        bit_sel;

	assign hp = (half_period == '0) ? {{(HalfW-1){1'b0}}, 1'b1} : half_period;

	// k / 3 for k below 24 as (k * 11) >> 5; only used while writing, where k is the index
	assign k11     = {4'b0, idx_q} * 9'd11;
	assign quot    = k11[IdxW+2:IdxW];
	assign sub     = 2'(idx_q - 5'(quot) * 5'd3);
	assign bit_sel = 3'd7 - quot;

	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		shift_d = shift_q;
		cmd_d   = cmd_q;
		delay_d = delay_q;
		clk_d   = clk_q;
		drv_d   = drv_q;
		lvl_d   = lvl_q;
		done    = 1'b0;
		waiting = 1'b0;
		ph      = phase_q;
		k       = idx_q;
		do_adv  = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (item.kind) begin
				cmd_d   = item.command;
				shift_d = '0;
				ph      = PH_START;
				k       = '0;
				do_adv  = 1'b1;
			end
		end else if (delay_q > 16'd1) begin
			delay_d = delay_q - 16'd1;
		end else begin
			do_adv = 1'b1;
		end

		if (do_adv) begin
			phase_d = ph;
			case (ph)
				PH_START: begin
					case (k)
						5'd0: begin
							drv_d = 1'b1;
							lvl_d = 1'b1;
						end
						5'd1: clk_d = 1'b1;
						5'd2: lvl_d = 1'b0;
						5'd3: clk_d = 1'b0;
						5'd4: clk_d = 1'b1;
						5'd5: lvl_d = 1'b1;
						default: clk_d = 1'b0;
					endcase
					if (k >= StartLast) begin
						phase_d = PH_WRITE;
						idx_d   = '0;
					end else begin
						idx_d = k + 5'd1;
					end
				end
				PH_WRITE: begin
					if (k >= WriteLast) begin
						drv_d   = 1'b0;
						clk_d   = 1'b0;
						phase_d = PH_ACK_WAIT;
						idx_d   = '0;
					end else begin
						case (sub)
							2'd0:    clk_d = 1'b0;
							2'd1:    lvl_d = cmd_q[bit_sel];
							default: clk_d = 1'b1;
						endcase
						idx_d = k + 5'd1;
					end
				end
				PH_ACK_WAIT: begin
					if (!item.data_sample) begin
						clk_d   = 1'b1;
						phase_d = PH_ACK_CLOCK;
					end else begin
						waiting = 1'b1;
					end
				end
				PH_ACK_CLOCK: begin
					clk_d   = 1'b0;
					phase_d = (cmd_q == CmdTemp || cmd_q == CmdHumid) ? PH_MEAS_WAIT : PH_IDLE;
					idx_d   = '0;
				end
				PH_MEAS_WAIT: begin
					if (!item.data_sample) begin
						phase_d = PH_READ_HI;
						idx_d   = '0;
					end else begin
						waiting = 1'b1;
					end
				end
				PH_READ_HI, PH_READ_LO: begin
					if (!k[0]) begin
						clk_d = 1'b1;
					end else begin
						// shift in MSB first on the falling clock
						shift_d = {shift_q[ReadW-2:0], item.data_sample};
						clk_d   = 1'b0;
					end
					if (k >= ReadLast) begin
						phase_d = (ph == PH_READ_HI) ? PH_ACK_SEND : PH_NACK;
						idx_d   = '0;
					end else begin
						idx_d = k + 5'd1;
					end
				end
				PH_ACK_SEND: begin
					if (k == 5'd0) begin
						drv_d = 1'b1;
						lvl_d = 1'b0;
					end else if (k == 5'd1) begin
						clk_d = 1'b1;
					end else begin
						clk_d = 1'b0;
						drv_d = 1'b0;
					end
					if (k >= AckLast) begin
						phase_d = PH_READ_LO;
						idx_d   = '0;
					end else begin
						idx_d = k + 5'd1;
					end
				end
				PH_NACK: begin
					if (k == 5'd0) begin
						drv_d = 1'b1;
						lvl_d = 1'b1;
					end else if (k == 5'd1) begin
						clk_d = 1'b1;
					end else begin
						clk_d = 1'b0;
					end
					if (k >= AckLast) begin
						phase_d = PH_IDLE;
						idx_d   = '0;
						done    = 1'b1;
					end else begin
						idx_d = k + 5'd1;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					idx_d   = '0;
				end
			endcase
			delay_d = waiting ? '0 : hp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			shift_q <= '0;
			cmd_q   <= '0;
			delay_q <= '0;
			clk_q   <= 1'b1;
			drv_q   <= 1'b1;
			lvl_q   <= 1'b1;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			shift_q <= shift_d;
			cmd_q   <= cmd_d;
			delay_q <= delay_d;
			clk_q   <= clk_d;
			drv_q   <= drv_d;
			lvl_q   <= lvl_d;
		end
	end

	always_comb begin
		result.clock_level   = clk_d;
		result.data_drive    = drv_d;
		result.data_level    = lvl_d;
		result.busy_res      = (phase_d != PH_IDLE);
		result.reading_valid = done;
		result.reading       = done ? shift_d : '0;
	end

endmodule

FILE: tb/tb_two_wire_humidity_sensor_master.sv
// Self-checking bench for two_wire_humidity_sensor_master: a sensor-side stimulus
// generator, an in-bench line sequencer model and a per-tick line state compare.
// Depends on thsm_pkg and the RTL only.
module tb_two_wire_humidity_sensor_master;
	timeunit 1ns;
	timeprecision 1ps;

	import thsm_pkg::*;

	localparam int QuietLimit = 1000;
	localparam int SegItems   = 360;
	localparam int DirRows    = 21;
	localparam int ZeroHalfRow = 2;
	localparam logic [CmdW-1:0] CmdSoftReset = 8'd30;

	localparam result_t ResIdle = {1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000};
	localparam result_t ResBusy = {1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000};
	localparam result_t NoRes   = '0;

	typedef struct packed {
		logic    typed;
		item_t   it;
		result_t res;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [DataW-1:0] pwdata = '0;
	logic [DataW-1:0] prdata;
	logic             pready;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             kind = 1'b0;
	logic [CmdW-1:0]  command = '0;
	logic             data_sample = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             clock_level;
	logic             data_drive;
	logic             data_level;
	logic             busy_res;
	logic             reading_valid;
	logic [ReadW-1:0] reading;

	two_wire_humidity_sensor_master DUT (.*);

	always #1 clk = ~clk;

	// line sequencer model
	phase_t           seq_phase;
	logic [IdxW-1:0]  seq_idx;
	logic [ReadW-1:0] seq_shift;
	logic [CmdW-1:0]  seq_cmd;
	logic [HalfW-1:0] seq_delay;
	logic [HalfW-1:0] half_ticks;
	logic             line_clk, line_drv, line_lvl;

	result_t pending_lines [$];
	int mismatches = 0;
	int ticks_sent = 0;
	int lines_checked = 0;
	int readings_done = 0;
	int seqs_started = 0;
	int quiet = 0;
	bit src_calm = 1'b0;
	bit sink_calm = 1'b0;
	int sink_hold = 0;

	dir_row_t dir_table [DirRows] = '{
		{1'b1, {1'b0, 8'h00, 1'b0}, ResIdle},
		{1'b1, {1'b0, 8'hFF, 1'b1}, ResIdle},
		{1'b1, {1'b0, 8'hAA, 1'b0}, ResIdle},
		{1'b1, {1'b1, CmdTemp, 1'b1}, ResBusy},
		{1'b0, {1'b1, 8'hFF, 1'b0}, NoRes},
		{1'b0, {1'b0, 8'h55, 1'b1}, NoRes},
		{1'b0, {1'b0, 8'h0F, 1'b0}, NoRes},
		{1'b0, {1'b0, 8'hF0, 1'b1}, NoRes},
		{1'b0, {1'b1, 8'h00, 1'b1}, NoRes},
		{1'b0, {1'b0, 8'h81, 1'b0}, NoRes},
		{1'b0, {1'b0, 8'h7E, 1'b1}, NoRes},
		{1'b0, {1'b0, 8'h33, 1'b0}, NoRes},
		{1'b0, {1'b0, 8'hCC, 1'b1}, NoRes},
		{1'b0, {1'b0, 8'h01, 1'b0}, NoRes},
		{1'b0, {1'b0, 8'h80, 1'b1}, NoRes},
		{1'b0, {1'b0, 8'h3C, 1'b0}, NoRes},
		{1'b0, {1'b0, 8'hC3, 1'b1}, NoRes},
		{1'b0, {1'b0, 8'h18, 1'b0}, NoRes},
		{1'b0, {1'b0, 8'hE7, 1'b1}, NoRes},
		{1'b0, {1'b0, 8'h66, 1'b0}, NoRes},
		{1'b0, {1'b0, 8'h99, 1'b1}, NoRes}
	};

	// One line step; returns 1 when the NACK after the second data byte has been sent.
	function automatic logic step_line(logic d);
		int   k;
		logic done;
		logic waiting;
		k = seq_idx;
		done = 1'b0;
		waiting = 1'b0;
		case (seq_phase)
		PH_START: begin
			case (k)
			0: begin
				line_drv = 1'b1;
				line_lvl = 1'b1;
			end
			1: line_clk = 1'b1;
			2: line_lvl = 1'b0;
			3: line_clk = 1'b0;
			4: line_clk = 1'b1;
			5: line_lvl = 1'b1;
			default: line_clk = 1'b0;
			endcase
			if (k >= StartLast) begin
				seq_phase = PH_WRITE;
				seq_idx = '0;
			end else seq_idx = IdxW'(k + 1);
		end
		PH_WRITE: begin
			if (k >= WriteLast) begin
				line_drv = 1'b0;
				line_clk = 1'b0;
				seq_phase = PH_ACK_WAIT;
				seq_idx = '0;
			end else begin
				if (k % 3 == 0) line_clk = 1'b0;
				else if (k % 3 == 1) line_lvl = seq_cmd[7 - k / 3];
				else line_clk = 1'b1;
				seq_idx = IdxW'(k + 1);
			end
		end
		PH_ACK_WAIT: begin
			if (!d) begin
				line_clk = 1'b1;
				seq_phase = PH_ACK_CLOCK;
			end else waiting = 1'b1;
		end
		PH_ACK_CLOCK: begin
			line_clk = 1'b0;
			seq_phase = (seq_cmd == CmdTemp || seq_cmd == CmdHumid) ? PH_MEAS_WAIT : PH_IDLE;
			seq_idx = '0;
		end
		PH_MEAS_WAIT: begin
			if (!d) begin
				seq_phase = PH_READ_HI;
				seq_idx = '0;
			end else waiting = 1'b1;
		end
		PH_READ_HI, PH_READ_LO: begin
			if (k % 2 == 0) line_clk = 1'b1;
			else begin
				seq_shift = {seq_shift[ReadW-2:0], d};
				line_clk = 1'b0;
			end
			if (k >= ReadLast) begin
				seq_phase = (seq_phase == PH_READ_HI) ? PH_ACK_SEND : PH_NACK;
				seq_idx = '0;
			end else seq_idx = IdxW'(k + 1);
		end
		PH_ACK_SEND: begin
			if (k == 0) begin
				line_drv = 1'b1;
				line_lvl = 1'b0;
			end else if (k == 1) line_clk = 1'b1;
			else begin
				line_clk = 1'b0;
				line_drv = 1'b0;
			end
			if (k >= AckLast) begin
				seq_phase = PH_READ_LO;
				seq_idx = '0;
			end else seq_idx = IdxW'(k + 1);
		end
		PH_NACK: begin
			if (k == 0) begin
				line_drv = 1'b1;
				line_lvl = 1'b1;
			end else if (k == 1) line_clk = 1'b1;
			else line_clk = 1'b0;
			if (k >= AckLast) begin
				seq_phase = PH_IDLE;
				seq_idx = '0;
				done = 1'b1;
			end else seq_idx = IdxW'(k + 1);
		end
		default: begin
			seq_phase = PH_IDLE;
			seq_idx = '0;
		end
		endcase
		// a zero half period behaves as one
		seq_delay = waiting ? '0 : ((half_ticks == 0) ? 16'd1 : half_ticks);
		return done;
	endfunction

	function automatic result_t master_tick(item_t it);
		result_t r;
		logic    done;
		done = 1'b0;
		if (seq_phase == PH_IDLE) begin
			if (it.kind) begin
				seq_cmd = it.command;
				seq_shift = '0;
				seq_phase = PH_START;
				seq_idx = '0;
				done = step_line(it.data_sample);
			end
		end else if (seq_delay > 1) seq_delay = seq_delay - 16'd1;
		else done = step_line(it.data_sample);
		r.clock_level = line_clk;
		r.data_drive = line_drv;
		r.data_level = line_lvl;
		r.busy_res = (seq_phase != PH_IDLE);
		r.reading_valid = done;
		r.reading = done ? seq_shift : '0;
		return r;
	endfunction

	// As the sensor: ack and end measuring after a random delay; also start requests.
	function automatic item_t sensor_item(bit may_start);
		item_t it;
		it.kind = 1'b0;
		it.command = 8'($urandom_range(0, 255));
		it.data_sample = 1'($urandom_range(0, 1));
		case (seq_phase)
		PH_IDLE: begin
			if (may_start && $urandom_range(0, 3) == 0) begin
				it.kind = 1'b1;
				case ($urandom_range(0, 9))
				0, 1, 2, 3: it.command = CmdTemp;
				4, 5, 6, 7: it.command = CmdHumid;
				8: it.command = CmdSoftReset;
				default: ;
				endcase
			end
		end
		PH_ACK_WAIT, PH_MEAS_WAIT: it.data_sample = ($urandom_range(0, 3) != 0);
		default: if ($urandom_range(0, 31) == 0) it.kind = 1'b1;
		endcase
		return it;
	endfunction

	function automatic int draw_wait(bit calm);
		return calm ? 0 : $urandom_range(0, 11);
	endfunction

	task automatic send_item(item_t it, logic typed = 1'b0, result_t typed_res = '0);
		int      gap;
		result_t r;
		if ($urandom_range(0, 63) == 0) src_calm = !src_calm;
		gap = draw_wait(src_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= it.kind;
		command <= it.command;
		data_sample <= it.data_sample;
		do @(posedge clk); while (!in_ready);
		if (it.kind && seq_phase == PH_IDLE) seqs_started++;
		r = master_tick(it);
		pending_lines.push_back(typed ? typed_res : r);
		ticks_sent++;
	endtask

	// Hold the input until every result is back, plus the pipeline depth.
	task automatic drain_lines();
		in_valid <= 1'b0;
		while (pending_lines.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_half(logic [HalfW-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrHalf;
		pwdata <= {16'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		half_ticks = v;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic void cmp_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// result side: random stall before each transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if ($urandom_range(0, 63) == 0) sink_calm = !sink_calm;
				sink_hold = draw_wait(sink_calm);
				out_ready <= (sink_hold == 0);
			end else if (sink_hold > 0) begin
				sink_hold--;
				if (sink_hold == 0) out_ready <= 1'b1;
			end else out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_lines.size() == 0) begin
				$display("%0t: result with nothing pending, got %0h", $time,
					{clock_level, data_drive, data_level, busy_res, reading_valid, reading});
				mismatches++;
			end else begin
				want = pending_lines.pop_front();
				cmp_field("clock_level", want.clock_level, clock_level);
				cmp_field("data_drive", want.data_drive, data_drive);
				cmp_field("data_level", want.data_level, data_level);
				cmp_field("busy_res", want.busy_res, busy_res);
				cmp_field("reading_valid", want.reading_valid, reading_valid);
				cmp_field("reading", want.reading, reading);
				lines_checked++;
				if (reading_valid) readings_done++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
			if (quiet >= QuietLimit) begin
				$display("%0t: no transfer for %0d cycles", $time, QuietLimit);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int               seg;
		int               n;
		logic [HalfW-1:0] hv;
		item_t            hum;
		seq_phase = PH_IDLE;
		seq_idx = '0;
		seq_shift = '0;
		seq_cmd = '0;
		seq_delay = '0;
		half_ticks = HalfReset;
		line_clk = 1'b1;
		line_drv = 1'b1;
		line_lvl = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < DirRows; n++) begin
			if (n == ZeroHalfRow) begin
				drain_lines();
				write_half('0);
			end
			send_item(dir_table[n].it, dir_table[n].typed, dir_table[n].res);
		end

		// first segment keeps the zero half period from the directed rows
		for (seg = 0; seg < 5; seg++) begin
			if (seg > 0) begin
				drain_lines();
				case (seg)
				2: hv = 16'd2;
				3: hv = 16'($urandom_range(3, 5));
				default: hv = 16'd1;
				endcase
				write_half(hv);
			end
			for (n = 0; n < SegItems; n++) send_item(sensor_item(1'b1));
			while (seq_phase != PH_IDLE) send_item(sensor_item(1'b0));
		end

		// slowest clock: only the first steps of a humidity request fit
		drain_lines();
		write_half(16'hFFFF);
		hum.kind = 1'b1;
		hum.command = CmdHumid;
		hum.data_sample = 1'b1;
		send_item(hum);
		for (n = 0; n < 40; n++) send_item(sensor_item(1'b0));

		in_valid <= 1'b0;
		while (pending_lines.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d ticks, %0d line states checked, %0d sequences, %0d readings", ticks_sent,
			lines_checked, seqs_started, readings_done);
		$display("half periods 80 while idle, then 0, 1, 2, 3 to 5 and 65535 with random stalls");
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/thsm_pkg.sv
sv/thsm_cfg.sv
sv/thsm_seq.sv
sv/two_wire_humidity_sensor_master.sv
tb/tb_two_wire_humidity_sensor_master.sv
